// File: sv/spi_mfe_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package spi_mfe_pkg;

  localparam int unsigned CS_PINS = 8;
  localparam int unsigned WORD_BITS = 32;

  typedef enum logic [4:0] {
    PH_IDLE   = 5'b00001,
    PH_SETUP  = 5'b00010,
    PH_FIRST  = 5'b00100,
    PH_SECOND = 5'b01000,
    PH_HOLD   = 5'b10000
  } phase_e;

  typedef enum logic [2:0] {
    CFG_CLK_IDLE_HIGH  = 3'd0,
    CFG_CS_ACTIVE_LOW  = 3'd1,
    CFG_LSB_FIRST      = 3'd2,
    CFG_HALF_BIT_DELAY = 3'd3,
    CFG_FRAME_BITS     = 3'd4,
    CFG_CS_LINE_COUNT  = 3'd5,
    CFG_CS_SELECT_MASK = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic               clk_idle_high;
    logic               cs_active_low;
    logic               lsb_first;
    logic               half_bit_delay;
    logic [5:0]         eff_frame;
    logic [3:0]         eff_lines;
    logic [CS_PINS-1:0] select_mask;
  } cfg_t;

  typedef struct packed {
    logic                 cmd;
    logic [WORD_BITS-1:0] tx_word;
    logic                 miso_level;
  } in_item_t;

  typedef struct packed {
    logic                 sclk_level;
    logic                 mosi_level;
    logic [CS_PINS-1:0]   cs_levels;
    logic                 busy_res;
    logic                 frame_done;
    logic [WORD_BITS-1:0] rx_word;
    logic                 start_refused;
  } out_item_t;

endpackage

`default_nettype wire

// File: sv/spi_mfe_chan_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface spi_mfe_chan_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: sv/spi_master_frame_engine.sv
// Latency: a result is valid in the cycle after its input transaction is accepted.
// Throughput: one transaction per cycle; the single output register is refilled in
// the same cycle that its result is taken, so input ready only drops on a stalled output.
// Reset: asynchronous, active low; returns the frame engine to idle with chip select
// deasserted and all configuration registers at their defaults.
`timescale 1ns / 1ps
`default_nettype none

module spi_master_frame_engine
  import spi_mfe_pkg::*;
#(
  parameter int unsigned MAX_CS_LINES   = 8,
  parameter int unsigned MAX_FRAME_BITS = 32,
  parameter int unsigned HALF_BIT_TICKS = 4,
  parameter int unsigned CS_SETUP_TICKS = 4
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  spi_mfe_chan_if.sink    in_ch,
  spi_mfe_chan_if.source  out_ch,
  input  wire logic       cfg_we_i,
  input  wire logic [2:0] cfg_idx_i,
  input  wire logic [7:0] cfg_data_i
);

  cfg_t      cfg;
  out_item_t res;
  out_item_t out_q;
  logic      out_valid_q;
  logic      idle;
  logic      fire;

  assign in_ch.ready = !out_valid_q || out_ch.ready;
  assign fire        = in_ch.valid && in_ch.ready;

  spi_mfe_cfg #(
    .MAX_CS_LINES  (MAX_CS_LINES),
    .MAX_FRAME_BITS(MAX_FRAME_BITS)
  ) u_cfg (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .we_i  (cfg_we_i),
    .idx_i (cfg_idx_i),
    .data_i(cfg_data_i),
    .idle_i(idle),
    .cfg_o (cfg)
  );

  spi_mfe_core #(
    .HALF_BIT_TICKS(HALF_BIT_TICKS),
    .CS_SETUP_TICKS(CS_SETUP_TICKS)
  ) u_core (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .fire_i(fire),
    .item_i(in_ch.data),
    .cfg_i (cfg),
    .idle_o(idle),
    .res_o (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire) begin
      out_valid_q <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_q <= res;
    end
  end

  assign out_ch.valid = out_valid_q;
  assign out_ch.data  = out_q;

endmodule

`default_nettype wire

// File: sv/spi_mfe_cfg.sv
`timescale 1ns / 1ps
`default_nettype none

module spi_mfe_cfg
  import spi_mfe_pkg::*;
#(
  parameter int unsigned MAX_CS_LINES   = 8,
  parameter int unsigned MAX_FRAME_BITS = 32
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       we_i,
  input  wire logic [2:0] idx_i,
  input  wire logic [7:0] data_i,
  input  wire logic       idle_i,
  output cfg_t            cfg_o
);

  localparam int unsigned LINE_CAP = (MAX_CS_LINES < CS_PINS) ? MAX_CS_LINES : CS_PINS;
  localparam int unsigned FRAME_CAP = (MAX_FRAME_BITS < WORD_BITS) ? MAX_FRAME_BITS : WORD_BITS;

  logic               clk_idle_high_q;
  logic               cs_active_low_q;
  logic               lsb_first_q;
  logic               half_bit_delay_q;
  logic [5:0]         frame_bits_q;
  logic [3:0]         line_count_q;
  logic [CS_PINS-1:0] select_mask_q;
  logic [3:0]         eff_lines;
  logic [5:0]         eff_frame;
  logic               mask_ok;

  assign eff_lines = (line_count_q > 4'(LINE_CAP)) ? 4'(LINE_CAP) : line_count_q;
  assign eff_frame = (frame_bits_q > 6'(FRAME_CAP)) ? 6'(FRAME_CAP) : frame_bits_q;
  assign mask_ok = ((9'(data_i) >> eff_lines) == 9'd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clk_idle_high_q  <= 1'b0;
      cs_active_low_q  <= 1'b1;
      lsb_first_q      <= 1'b0;
      half_bit_delay_q <= 1'b1;
      frame_bits_q     <= 6'd8;
      line_count_q     <= 4'd1;
      select_mask_q    <= 8'd1;
    end else if (we_i && idle_i) begin
      unique case (cfg_idx_e'(idx_i))
        CFG_CLK_IDLE_HIGH:  clk_idle_high_q  <= data_i[0];
        CFG_CS_ACTIVE_LOW:  cs_active_low_q  <= data_i[0];
        CFG_LSB_FIRST:      lsb_first_q      <= data_i[0];
        CFG_HALF_BIT_DELAY: half_bit_delay_q <= data_i[0];
        CFG_FRAME_BITS:     frame_bits_q     <= data_i[5:0];
        CFG_CS_LINE_COUNT:  line_count_q     <= data_i[3:0];
        CFG_CS_SELECT_MASK: begin
          if (mask_ok) begin
            select_mask_q <= data_i;
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg_o.clk_idle_high  = clk_idle_high_q;
    cfg_o.cs_active_low  = cs_active_low_q;
    cfg_o.lsb_first      = lsb_first_q;
    cfg_o.half_bit_delay = half_bit_delay_q;
    cfg_o.eff_frame      = eff_frame;
    cfg_o.eff_lines      = eff_lines;
    cfg_o.select_mask    = select_mask_q;
  end

endmodule

`default_nettype wire

// File: sv/spi_mfe_core.sv
`timescale 1ns / 1ps
`default_nettype none

module spi_mfe_core
  import spi_mfe_pkg::*;
#(
  parameter int unsigned HALF_BIT_TICKS = 4,
  parameter int unsigned CS_SETUP_TICKS = 4
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     fire_i,
  input  wire in_item_t item_i,
  input  wire cfg_t     cfg_i,
  output logic          idle_o,
  output out_item_t     res_o
);

  localparam logic [15:0] HALF_LEN  = 16'(HALF_BIT_TICKS);
  localparam logic [15:0] SETUP_LEN = 16'(CS_SETUP_TICKS);

  phase_e                phase_q, phase_d;
  logic [15:0]           tick_q, tick_d, tick_inc;
  logic [5:0]            bit_q, bit_d;
  logic [WORD_BITS-1:0]  tx_q, tx_d, rx_q, rx_d;
  logic                  sclk_q, sclk_d, mosi_q, mosi_d, cs_q, cs_d;
  logic                  done, refused, enter_bit, setup_over, half_over;
  logic [CS_PINS-1:0]    cs_pins;

  function automatic logic [4:0] bit_pos(logic lsb, logic [5:0] n, logic [5:0] idx);
    logic [5:0] rev;
    rev = n - 6'd1 - idx;
    return lsb ? idx[4:0] : rev[4:0];
  endfunction

  assign tick_inc   = tick_q + 16'd1;
  assign setup_over = (tick_inc >= SETUP_LEN);
  assign half_over  = (tick_inc >= HALF_LEN);

  always_comb begin
    phase_d   = phase_q;
    tick_d    = tick_q;
    bit_d     = bit_q;
    tx_d      = tx_q;
    rx_d      = rx_q;
    sclk_d    = sclk_q;
    mosi_d    = mosi_q;
    cs_d      = cs_q;
    done      = 1'b0;
    refused   = 1'b0;
    enter_bit = 1'b0;

    if (item_i.cmd) begin
      if (phase_q != PH_IDLE) begin
        refused = 1'b1;
      end else begin
        tx_d    = item_i.tx_word;
        rx_d    = '0;
        bit_d   = 6'd0;
        tick_d  = 16'd0;
        sclk_d  = 1'b0;
        cs_d    = 1'b1;
        phase_d = PH_SETUP;
        if (CS_SETUP_TICKS == 0) begin
          enter_bit = 1'b1;
        end
      end
    end else begin
      unique case (phase_q)
        PH_SETUP: begin
          tick_d = tick_inc;
          if (setup_over) begin
            enter_bit = 1'b1;
          end
        end
        PH_FIRST: begin
          tick_d = tick_inc;
          if (half_over) begin
            if (item_i.miso_level) begin
              rx_d[bit_pos(cfg_i.lsb_first, cfg_i.eff_frame, bit_q)] = 1'b1;
            end
            sclk_d  = cfg_i.half_bit_delay;
            phase_d = PH_SECOND;
            tick_d  = 16'd0;
          end
        end
        PH_SECOND: begin
          tick_d = tick_inc;
          if (half_over) begin
            sclk_d    = 1'b0;
            bit_d     = bit_q + 6'd1;
            enter_bit = 1'b1;
          end
        end
        PH_HOLD: begin
          tick_d = tick_inc;
          if (setup_over) begin
            cs_d    = 1'b0;
            done    = 1'b1;
            phase_d = PH_IDLE;
          end
        end
        default: ;
      endcase
    end

    if (enter_bit) begin
      tick_d = 16'd0;
      if (bit_d >= cfg_i.eff_frame) begin
        phase_d = PH_HOLD;
        if (CS_SETUP_TICKS == 0) begin
          cs_d    = 1'b0;
          done    = 1'b1;
          phase_d = PH_IDLE;
        end
      end else begin
        mosi_d = tx_d[bit_pos(cfg_i.lsb_first, cfg_i.eff_frame, bit_d)];
        if (!cfg_i.half_bit_delay) begin
          sclk_d = 1'b1;
        end
        phase_d = PH_FIRST;
      end
    end
  end

  always_comb begin
    for (int i = 0; i < CS_PINS; i++) begin
      cs_pins[i] = (4'(i) < cfg_i.eff_lines) ?
                   ((cs_d & cfg_i.select_mask[i]) ^ cfg_i.cs_active_low) : 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      tick_q  <= 16'd0;
      bit_q   <= 6'd0;
      tx_q    <= '0;
      rx_q    <= '0;
      sclk_q  <= 1'b0;
      mosi_q  <= 1'b0;
      cs_q    <= 1'b0;
    end else if (fire_i) begin
      phase_q <= phase_d;
      tick_q  <= tick_d;
      bit_q   <= bit_d;
      tx_q    <= tx_d;
      rx_q    <= rx_d;
      sclk_q  <= sclk_d;
      mosi_q  <= mosi_d;
      cs_q    <= cs_d;
    end
  end

  assign idle_o = (phase_q == PH_IDLE);

  always_comb begin
    res_o.sclk_level    = sclk_d ^ cfg_i.clk_idle_high;
    res_o.mosi_level    = mosi_d;
    res_o.cs_levels     = cs_pins;
    res_o.busy_res      = (phase_d != PH_IDLE);
    res_o.frame_done    = done;
    res_o.rx_word       = done ? rx_d : '0;
    res_o.start_refused = refused;
  end

`ifndef SYNTH
  a_cs_held_in_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q != PH_IDLE) |-> cs_q)
    else $error("Chip select dropped while a frame is in progress.");

  a_bit_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q != PH_IDLE) |-> (bit_q <= cfg_i.eff_frame))
    else $error("Bit index ran past the frame length.");

  a_half_tick_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_FIRST || phase_q == PH_SECOND) |-> (tick_q < HALF_LEN))
    else $error("Half-bit counter exceeded its length.");

  a_first_to_second: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire_i && !item_i.cmd && phase_q == PH_FIRST) |=>
      (phase_q == PH_FIRST || phase_q == PH_SECOND))
    else $error("First half of a bit left for a phase other than the second half.");

  a_refused_keeps_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire_i && item_i.cmd && phase_q != PH_IDLE) |=>
      ($stable(tick_q) && $stable(bit_q) && $stable(rx_q)))
    else $error("A refused start changed the frame state.");
`endif

endmodule

`default_nettype wire
